// File: rtl/sha1md_pkg.sv
`timescale 1ns / 1ps

package sha1md_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] LAST_IDX   = 3'd4;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] LOAD_LAST  = 7'd15;
  localparam logic [3:0] LEN_HI_IDX = 4'd14;
  localparam logic [3:0] LEN_LO_IDX = 4'd15;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_item_t;

  typedef struct packed {
    logic        blk_end;
    logic [31:0] word;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: rtl/sha1md_in_if.sv
`timescale 1ns / 1ps

interface sha1md_in_if;
  logic                  valid;
  logic                  ready;
  sha1md_pkg::msg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sha1md_out_if.sv
`timescale 1ns / 1ps

interface sha1md_out_if;
  logic                  valid;
  logic                  ready;
  sha1md_pkg::dig_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sha1_message_digest_core.sv
`timescale 1ns / 1ps

// SHA-1 over a byte stream. Each msg word carries at most one message byte; a word marked
// last ends the message, and five digest words (index 0 first) follow on dig. The front
// takes one byte per cycle while the queue has room and no padding is being pushed, and
// packs four bytes per word into a four-word queue. Rounds 0-15 take their schedule words
// straight from the queue, so they wait on the front. During rounds 16-79 and the chaining
// add, the full queue keeps the front only 16 bytes ahead. Padding adds one or two blocks
// after the last word, each run as 80 rounds and one chaining add, before the five digest
// words go out; msg keeps taking bytes of the next message while the digest drains, until
// the queue fills.

module sha1_message_digest_core (
  input  logic         clk,
  input  logic         rst,
  sha1md_in_if.sink    msg,
  sha1md_out_if.source dig
);

  logic               push;
  logic               pop;
  sha1md_pkg::qword_t push_word;
  sha1md_pkg::qword_t pop_word;
  sha1md_pkg::qstat_t qstat;

  sha1md_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .push      (push),
    .push_word (push_word),
    .qstat     (qstat)
  );

  sha1md_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .qstat     (qstat)
  );

  sha1md_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_word (pop_word),
    .qstat    (qstat),
    .dig      (dig)
  );

endmodule

// File: rtl/sha1md_fifo.sv
`timescale 1ns / 1ps

module sha1md_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sha1md_pkg::qword_t push_word,
  input  logic               pop,
  output sha1md_pkg::qword_t pop_word,
  output sha1md_pkg::qstat_t qstat
);

  sha1md_pkg::qword_t          mem [sha1md_pkg::QDEPTH];
  logic [sha1md_pkg::QAW-1:0]  wptr;
  logic [sha1md_pkg::QAW-1:0]  rptr;
  logic [sha1md_pkg::QCW-1:0]  cnt;

  assign qstat.full  = (cnt == sha1md_pkg::QCW'(sha1md_pkg::QDEPTH));
  assign qstat.empty = (cnt == '0);
  assign pop_word    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: rtl/sha1md_front.sv
`timescale 1ns / 1ps

module sha1md_front (
  input  logic               clk,
  input  logic               rst,
  sha1md_in_if.sink          msg,
  output logic               push,
  output sha1md_pkg::qword_t push_word,
  input  sha1md_pkg::qstat_t qstat
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_PAD  = 1'b1;

  logic        state;
  logic [60:0] total;
  logic [60:0] total_inc;
  logic [23:0] acc;
  logic [3:0]  wc;
  logic        len_ok;
  logic        pad_first;
  logic        take;
  logic [63:0] bits;
  logic [31:0] first_word;
  logic [31:0] pad_word;

  assign msg.ready = (state == ST_LOAD) && !qstat.full;
  assign take      = msg.valid && msg.ready;
  assign total_inc = msg.data.byte_present ? total + 61'd1 : total;
  assign bits      = {total, 3'b000};

  always_comb begin
    case (total[1:0])
      2'd0:    first_word = {sha1md_pkg::PAD_BYTE, 24'h0};
      2'd1:    first_word = {acc[7:0], sha1md_pkg::PAD_BYTE, 16'h0};
      2'd2:    first_word = {acc[15:0], sha1md_pkg::PAD_BYTE, 8'h0};
      default: first_word = {acc, sha1md_pkg::PAD_BYTE};
    endcase
  end

  always_comb begin
    if (pad_first) begin
      pad_word = first_word;
    end else if (len_ok && wc == sha1md_pkg::LEN_HI_IDX) begin
      pad_word = bits[63:32];
    end else if (len_ok && wc == sha1md_pkg::LEN_LO_IDX) begin
      pad_word = bits[31:0];
    end else begin
      pad_word = '0;
    end
  end

  always_comb begin
    if (state == ST_PAD) begin
      push              = !qstat.full;
      push_word.word    = pad_word;
      push_word.blk_end = len_ok && (wc == sha1md_pkg::LEN_LO_IDX);
    end else begin
      push              = take && msg.data.byte_present && (total[1:0] == 2'b11);
      push_word.word    = {acc, msg.data.data_byte};
      push_word.blk_end = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      total     <= '0;
      wc        <= '0;
      len_ok    <= 1'b0;
      pad_first <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (take) begin
            total <= total_inc;
            if (msg.data.last_byte) begin
              state     <= ST_PAD;
              wc        <= total_inc[5:2];
              len_ok    <= (total_inc[5:2] < sha1md_pkg::LEN_HI_IDX);
              pad_first <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          if (push) begin
            pad_first <= 1'b0;
            wc        <= wc + 1'b1;
            if (wc == sha1md_pkg::LEN_LO_IDX) begin
              if (len_ok) begin
                state <= ST_LOAD;
                total <= '0;
              end else begin
                len_ok <= 1'b1;
              end
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && msg.data.byte_present) begin
      acc <= {acc[15:0], msg.data.data_byte};
    end
  end

endmodule

// File: rtl/sha1md_engine.sv
`timescale 1ns / 1ps

module sha1md_engine (
  input  logic               clk,
  input  logic               rst,
  output logic               pop,
  input  sha1md_pkg::qword_t pop_word,
  input  sha1md_pkg::qstat_t qstat,
  sha1md_out_if.source       dig
);

  localparam logic [1:0] ST_RND = 2'd0;
  localparam logic [1:0] ST_ADD = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0]        state;
  logic [6:0]        rnd;
  logic [2:0]        idx;
  logic              blk_end_seen;
  logic [4:0][31:0]  h;
  logic [4:0][31:0]  v;
  logic [4:0][31:0]  cur;
  logic [15:0][31:0] win;
  logic [31:0]       w_mix;
  logic [31:0]       w_sched;
  logic [31:0]       w;
  logic [31:0]       f;
  logic [31:0]       k;
  logic [31:0]       sum;
  logic              use_q;
  logic              step;

  assign cur     = (rnd == '0) ? h : v;
  assign w_mix   = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_sched = {w_mix[30:0], w_mix[31]};
  assign use_q   = (rnd <= sha1md_pkg::LOAD_LAST);
  assign w       = use_q ? pop_word.word : w_sched;
  assign step    = (state == ST_RND) && (!use_q || !qstat.empty);
  assign pop     = step && use_q;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (cur[1] & cur[2]) | (~cur[1] & cur[3]);
      k = sha1md_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = cur[1] ^ cur[2] ^ cur[3];
      k = sha1md_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (cur[1] & cur[2]) | (cur[1] & cur[3]) | (cur[2] & cur[3]);
      k = sha1md_pkg::K2;
    end else begin
      f = cur[1] ^ cur[2] ^ cur[3];
      k = sha1md_pkg::K3;
    end
  end

  assign sum = {cur[0][26:0], cur[0][31:27]} + f + cur[4] + k + w;

  assign dig.valid            = (state == ST_OUT);
  assign dig.data.digest_word = h[idx];
  assign dig.data.word_index  = idx;
  assign dig.data.last_word   = (idx == sha1md_pkg::LAST_IDX);

  always_ff @(posedge clk) begin
    if (step) begin
      v   <= {cur[3], cur[2], {cur[1][1:0], cur[1][31:2]}, cur[0], sum};
      win <= {w, win[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RND;
      rnd          <= '0;
      idx          <= '0;
      blk_end_seen <= 1'b0;
      h            <= sha1md_pkg::H_INIT;
    end else begin
      case (state)
        ST_RND: begin
          if (step) begin
            if (rnd == sha1md_pkg::LOAD_LAST) begin
              blk_end_seen <= pop_word.blk_end;
            end
            if (rnd == sha1md_pkg::ROUND_LAST) begin
              rnd   <= '0;
              state <= ST_ADD;
            end else begin
              rnd <= rnd + 1'b1;
            end
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 5; i++) begin
            h[i] <= h[i] + v[i];
          end
          state <= blk_end_seen ? ST_OUT : ST_RND;
        end
        ST_OUT: begin
          if (dig.ready) begin
            if (idx == sha1md_pkg::LAST_IDX) begin
              idx   <= '0;
              h     <= sha1md_pkg::H_INIT;
              state <= ST_RND;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= ST_RND;
      endcase
    end
  end

endmodule

// File: rtl/sha1md_checker.sv
`timescale 1ns / 1ps

module sha1md_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  dig_valid,
  input logic                  dig_ready,
  input sha1md_pkg::dig_item_t dig_data
);

  logic [2:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (dig_valid && dig_ready) begin
      exp_idx <= (exp_idx == sha1md_pkg::LAST_IDX) ? 3'd0 : exp_idx + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(dig_data))
    else $error("digest word changed while stalled");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> dig_data.word_index == exp_idx)
    else $error("digest word out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> dig_data.last_word == (dig_data.word_index == sha1md_pkg::LAST_IDX))
    else $error("last flag does not match index");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && !dig_data.last_word |=> dig_valid)
    else $error("gap inside a digest");

endmodule

bind sha1_message_digest_core sha1md_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .dig_valid (dig.valid),
  .dig_ready (dig.ready),
  .dig_data  (dig.data)
);
